FILE: design/saturating_integer_alu_defines.svh
// ----------------------------------------------------------------------------
// Saturating integer ALU assertion macros
// Shared assertion forms for the saturating integer ALU.
// ----------------------------------------------------------------------------
`ifndef SATURATING_INTEGER_ALU_DEFINES_SVH
`define SATURATING_INTEGER_ALU_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SIA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("saturating_integer_alu: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define SIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("saturating_integer_alu: next-cycle check failed");

`endif

FILE: design/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Types and constants shared by the saturating integer ALU modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int PORT_WIDTH = 64;
	localparam int HALF_WIDTH = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_MOD  = 3'd4,
		OP_MIN  = 3'd5,
		OP_MAX  = 3'd6,
		OP_ZERO = 3'd7
	} op_t;

	// Classified request as it travels from the front to the back.
	typedef struct packed {
		op_t                   op;
		logic                  div0;
		logic                  ovf;
		logic                  neg_q;
		logic                  neg_l;
		logic [DATA_WIDTH-1:0] res;
		logic [DATA_WIDTH-1:0] mag_l;
		logic [DATA_WIDTH-1:0] mag_r;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

FILE: design/sia_front.sv
// ----------------------------------------------------------------------------
// sia_front
// Decodes a request, finishes add, subtract, min and max, and prepares
// magnitudes and flags for multiply, divide and modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_front (
	input  wire logic                          req_valid,
	input  wire logic [2:0]                    req_type,
	input  wire logic [sia_pkg::PORT_WIDTH-1:0] left_operand,
	input  wire logic [sia_pkg::PORT_WIDTH-1:0] right_operand,
	input  wire sia_pkg::fifo_stat_t           stat,
	output logic                               push,
	output sia_pkg::cmd_t                      cmd
);

	logic [sia_pkg::DATA_WIDTH-1:0] l, r;
	logic [sia_pkg::DATA_WIDTH:0]   sum, dif;
	sia_pkg::op_t                   op;

	assign l   = left_operand[sia_pkg::DATA_WIDTH-1:0];
	assign r   = right_operand[sia_pkg::DATA_WIDTH-1:0];
	assign op  = sia_pkg::op_t'(req_type);
	assign sum = {l[sia_pkg::DATA_WIDTH-1], l} + {r[sia_pkg::DATA_WIDTH-1], r};
	assign dif = {l[sia_pkg::DATA_WIDTH-1], l} - {r[sia_pkg::DATA_WIDTH-1], r};

	assign push = req_valid && !stat.full;

	always_comb begin
		cmd.op    = op;
		cmd.div0  = (r == '0);
		cmd.ovf   = (l == sia_pkg::MIN_VAL) && (r == '1);
		cmd.neg_q = l[sia_pkg::DATA_WIDTH-1] ^ r[sia_pkg::DATA_WIDTH-1];
		cmd.neg_l = l[sia_pkg::DATA_WIDTH-1];
		cmd.mag_l = l[sia_pkg::DATA_WIDTH-1] ? (~l + 1'b1) : l;
		cmd.mag_r = r[sia_pkg::DATA_WIDTH-1] ? (~r + 1'b1) : r;
		case (op)
			sia_pkg::OP_ADD: begin
				if (sum[sia_pkg::DATA_WIDTH] != sum[sia_pkg::DATA_WIDTH-1])
					cmd.res = sum[sia_pkg::DATA_WIDTH] ? sia_pkg::MIN_VAL : sia_pkg::MAX_VAL;
				else
					cmd.res = sum[sia_pkg::DATA_WIDTH-1:0];
			end
			sia_pkg::OP_SUB: begin
				if (dif[sia_pkg::DATA_WIDTH] != dif[sia_pkg::DATA_WIDTH-1])
					cmd.res = dif[sia_pkg::DATA_WIDTH] ? sia_pkg::MIN_VAL : sia_pkg::MAX_VAL;
				else
					cmd.res = dif[sia_pkg::DATA_WIDTH-1:0];
			end
			sia_pkg::OP_MIN: cmd.res = ($signed(l) < $signed(r)) ? l : r;
			sia_pkg::OP_MAX: cmd.res = ($signed(l) > $signed(r)) ? l : r;
			default:         cmd.res = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/sia_fifo.sv
// ----------------------------------------------------------------------------
// sia_fifo
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sia_pkg::cmd_t       wdata,
	input  wire logic                pop,
	output sia_pkg::cmd_t            rdata,
	output sia_pkg::fifo_stat_t      stat
);

	sia_pkg::cmd_t                 mem_q [sia_pkg::FIFO_DEPTH];
	logic [sia_pkg::PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [sia_pkg::CNT_W-1:0]     count_q;

	assign stat.full  = (count_q == sia_pkg::CNT_W'(sia_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

FILE: design/sia_back.sv
// ----------------------------------------------------------------------------
// sia_back
// Execution pipeline: one restoring divide step per stage, a split multiplier
// in the first stages, and an output register toward the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sia_pkg::cmd_t            head,
	input  wire sia_pkg::fifo_stat_t      stat,
	output logic                          pop,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic [sia_pkg::DATA_WIDTH-1:0] result
);

	localparam int W  = sia_pkg::DATA_WIDTH;
	localparam int NS = sia_pkg::DATA_WIDTH;
	localparam int H  = sia_pkg::HALF_WIDTH;
	localparam int P  = sia_pkg::PORT_WIDTH;

	logic          en;
	logic          vld_s [NS];
	sia_pkg::cmd_t cmd_s [NS];
	logic [W-1:0]  rem_s [NS];
	logic [W-1:0]  quo_s [NS];

	logic [2*H-1:0] pp_s1 [4];
	logic [2*H-1:0] lo_s2, hi_s2;
	logic [2*H:0]   mid_s2;
	logic [4*H-1:0] full_s3;

	logic [P-1:0]   ml, mr;
	logic [4*H-1:0] lim;
	logic [W-1:0]   mul_res, final_res;
	sia_pkg::cmd_t  mul_cmd;
	logic           rsp_valid_q;
	logic [W-1:0]   result_q;

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
			input logic [W-1:0] quo, input logic [W-1:0] dvs);
		logic [W:0] part, diff;
		part = {rem, quo[W-1]};
		diff = part - {1'b0, dvs};
		if (!diff[W])
			return {diff[W-1:0], quo[W-2:0], 1'b1};
		else
			return {part[W-1:0], quo[W-2:0], 1'b0};
	endfunction

	assign en  = !rsp_valid_q || !rsp_stall;
	assign pop = en && !stat.empty;
	assign ml  = P'(head.mag_l);
	assign mr  = P'(head.mag_r);

	// Stage 0 takes the queue head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= pop;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s[0] <= head;
			{rem_s[0], quo_s[0]} <= div_step('0, head.mag_l, head.mag_r);
			pp_s1[0] <= ml[H-1:0] * mr[H-1:0];
			pp_s1[1] <= ml[2*H-1:H] * mr[H-1:0];
			pp_s1[2] <= ml[H-1:0] * mr[2*H-1:H];
			pp_s1[3] <= ml[2*H-1:H] * mr[2*H-1:H];
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				{rem_s[k], quo_s[k]} <= div_step(rem_s[k-1], quo_s[k-1], cmd_s[k-1].mag_r);
				cmd_s[k] <= (k == 3) ? mul_cmd : cmd_s[k-1];
			end
		end
	end

	// Multiplier: partial products, middle sum, full product, saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2   <= pp_s1[0];
			hi_s2   <= pp_s1[3];
			mid_s2  <= {1'b0, pp_s1[1]} + {1'b0, pp_s1[2]};
			full_s3 <= {hi_s2, lo_s2} + ((4*H)'(mid_s2) << H);
		end
	end

	always_comb begin
		lim = ((4*H)'(1) << (W - 1)) - (4*H)'(!cmd_s[2].neg_q);
		if (full_s3 > lim)
			mul_res = cmd_s[2].neg_q ? sia_pkg::MIN_VAL : sia_pkg::MAX_VAL;
		else if (cmd_s[2].neg_q)
			mul_res = ~full_s3[W-1:0] + 1'b1;
		else
			mul_res = full_s3[W-1:0];
	end

	// Merge the saturated product into the request entering stage 3.
	always_comb begin
		mul_cmd = cmd_s[2];
		if (cmd_s[2].op == sia_pkg::OP_MUL)
			mul_cmd.res = mul_res;
	end

	always_comb begin
		case (cmd_s[NS-1].op)
			sia_pkg::OP_DIV: begin
				if (cmd_s[NS-1].div0)
					final_res = '0;
				else if (cmd_s[NS-1].ovf)
					final_res = sia_pkg::MAX_VAL;
				else
					final_res = cmd_s[NS-1].neg_q ? (~quo_s[NS-1] + 1'b1) : quo_s[NS-1];
			end
			sia_pkg::OP_MOD: begin
				if (cmd_s[NS-1].div0 || cmd_s[NS-1].ovf)
					final_res = '0;
				else
					final_res = cmd_s[NS-1].neg_l ? (~rem_s[NS-1] + 1'b1) : rem_s[NS-1];
			end
			default: final_res = cmd_s[NS-1].res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (en)
			rsp_valid_q <= vld_s[NS-1];
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[NS-1])
			result_q <= final_res;
	end

	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

FILE: design/saturating_integer_alu.sv
// ----------------------------------------------------------------------------
// saturating_integer_alu
// Signed saturating ALU: add, sub, mul, div, mod, min, max on 64-bit operands.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  request   req_valid/req_stall   req_type, left_operand, right_operand
//  response  rsp_valid/rsp_stall   result_value
//
//  Throughput: one request per cycle while rsp_stall is low.
//  Path: into the queue, then through the back, whose depth is set by the
//  divider's one-bit-per-stage pipeline, then the output register; every
//  operation takes the same path so results leave in request order.
//  Reset clears only valid bits, queue pointers and count; no clearing pass.
//  A stalled waiting result freezes the whole back; the queue then fills and
//  raises req_stall.
//
`default_nettype none

`include "saturating_integer_alu_defines.svh"

module saturating_integer_alu (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [2:0]          req_type,
	input  wire logic signed [63:0]  left_operand,
	input  wire logic signed [63:0]  right_operand,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic signed [63:0]       result_value
);

	logic                           push, pop;
	sia_pkg::cmd_t                  front_cmd, head_cmd;
	sia_pkg::fifo_stat_t            stat;
	logic [sia_pkg::DATA_WIDTH-1:0] result;

	// Stall requests whenever the queue is full.
	assign req_stall = stat.full;

	// Decode and finish the simple operations.
	sia_front u_front (
		.req_valid     (req_valid),
		.req_type      (req_type),
		.left_operand  (left_operand),
		.right_operand (right_operand),
		.stat          (stat),
		.push          (push),
		.cmd           (front_cmd)
	);

	// Decouple request acceptance from the execution pipeline.
	sia_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.stat   (stat)
	);

	// Multiply and divide, then hold the result for the response side.
	sia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_cmd),
		.stat      (stat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.result    (result)
	);

	// Sign-extend the data-width result onto the port.
	assign result_value = 64'($signed(result));

	`SIA_ASSERT_SAME(a_no_overflow, clk, arst_n, push, !stat.full)
	`SIA_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, !stat.empty)
	`SIA_ASSERT_NEXT(a_accept_queued, clk, arst_n, req_valid && !req_stall, !stat.empty)

endmodule

`default_nettype wire
